// ----- rtl/pnt_pkg.sv -----
// Shared types and constants for the proximity neighbor table.
// Used by pnt_evout and proximity_neighbor_table; depends on nothing.
package pnt_pkg;

  // Table geometry. The home slot is the low bits of the node id, so the
  // table size stays a power of two.
  localparam int TABLE_SIZE  = 16;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int OCC_W       = $clog2(TABLE_SIZE + 1);
  localparam int MAX_RESULTS = 16;
  localparam int EVC_W       = $clog2(MAX_RESULTS + 1);

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_RSSI_THR  = 2'd0;
  localparam logic [1:0] REG_PROXIMITY = 2'd1;
  localparam logic [1:0] REG_AWAY      = 2'd2;
  localparam logic [1:0] REG_STALE     = 2'd3;

  localparam logic signed [7:0] RSSI_THR_RST  = -8'sd65;
  localparam logic [31:0]       PROXIMITY_RST = 32'd1920;
  localparam logic [31:0]       AWAY_RST      = 32'd3840;
  localparam logic [31:0]       STALE_RST     = 32'd426;

  typedef enum logic [1:0] {
    PH_NEAR    = 2'd0,
    PH_PRESENT = 2'd1,
    PH_AWAY    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_INSERTED = 3'd1,
    EV_DETECTED = 3'd2,
    EV_LEAVING  = 3'd3,
    EV_RETURNED = 3'd4,
    EV_ABSENT   = 3'd5,
    EV_REMOVED  = 3'd6,
    EV_FULL     = 3'd7
  } ev_res_t;

  typedef struct packed {
    logic [15:0] node;
    phase_t      phase;
    logic [31:0] detect;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    ev_res_t     res;
    logic [15:0] node;
    logic [31:0] etime;
  } event_t;

  // push: one event of the item, more may follow
  // fin:  close the item; the held event, or the given one, goes out as last
  typedef struct packed {
    logic push;
    logic fin;
  } evctl_t;

endpackage

// ----- rtl/pnt_evout.sv -----
// Result stage: one held event plus the output register of the result stream.
// Depends on pnt_pkg (event_t, evctl_t).
module pnt_evout (
  input  logic            clk,
  input  logic            rst_n,
  input  pnt_pkg::evctl_t ctl,
  input  pnt_pkg::event_t ev,
  output logic            ev_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [47:0]     out_tdata,   // event_node[15:0], event_time[47:16]
  output logic [2:0]      out_tuser,   // event_res[2:0]
  output logic            out_tlast
);
  import pnt_pkg::*;

  logic   pend_vld_r, pend_vld_nxt;
  event_t pend_r, pend_nxt;
  logic   out_vld_r, out_vld_nxt;
  event_t out_r, out_nxt;
  logic   last_r, last_nxt;

  assign ev_ready = !out_vld_r || out_tready;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    last_nxt     = last_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (ctl.push && ev_ready) begin
      // release the older event, hold the new one until we know it is not last
      if (pend_vld_r) begin
        out_nxt     = pend_r;
        last_nxt    = 1'b0;
        out_vld_nxt = 1'b1;
      end
      pend_nxt     = ev;
      pend_vld_nxt = 1'b1;
    end else if (ctl.fin && ev_ready) begin
      out_nxt      = pend_vld_r ? pend_r : ev;
      last_nxt     = 1'b1;
      out_vld_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.etime, out_r.node};
  assign out_tuser  = out_r.res;
  assign out_tlast  = last_r;

  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.fin))
    else $error("push and fin raised together");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin && ev_ready) |=> (out_tvalid && out_tlast))
    else $error("closing an item did not present a last result");

  a_not_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> pend_vld_r)
    else $error("non-last result without a following held event");

endmodule

// ----- rtl/proximity_neighbor_table.sv -----
// Proximity neighbor table top level: sequencer, table memory, valid bits, occupancy
// and configuration registers; depends on pnt_pkg and pnt_evout.
// A packet transaction reads one table slot per probed slot, stopping at the match; a
//   sweep walks the slots in order, and either may wait on output stalls.
// The final result appears on out_* in the cycle after the last table step; the next
//   item is taken while it waits. Reset clears valid bits, occupancy and registers.
module proximity_neighbor_table (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // node_id[15:0], rssi[23:16], now[55:24]
  input  logic        in_tuser,   // cmd[0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // event_node[15:0], event_time[47:16]
  output logic [2:0]  out_tuser,  // event_res[2:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pnt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_PK_SCAN = 5'b00010,
    S_PK_ACT  = 5'b00100,
    S_SW_EVAL = 5'b01000,
    S_SW_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // item fields
  logic               cmd_r, cmd_nxt;
  logic [15:0]        node_r, node_nxt;
  logic signed [7:0]  rssi_r, rssi_nxt;
  logic [31:0]        now_r, now_nxt;

  // walk control
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic               hit_r, hit_nxt;
  logic               free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]  free_slot_r, free_slot_nxt;
  logic [EVC_W-1:0]   evcnt_r, evcnt_nxt;

  // table state
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;

  // configuration
  logic signed [7:0]  rssi_thr_r;
  logic [31:0]        prox_r, away_r, stale_r;

  // table memory, registered read
  entry_t             mem [TABLE_SIZE];
  entry_t             rdata_r;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  entry_t             wr_data;

  // result path
  evctl_t             ev_ctl;
  event_t             ev_data;
  logic               ev_ready;

  logic               in_acc;
  logic               cfg_wr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RSSI_THR:  cfg_prdata = {24'd0, rssi_thr_r};
      REG_PROXIMITY: cfg_prdata = prox_r;
      REG_AWAY:      cfg_prdata = away_r;
      REG_STALE:     cfg_prdata = stale_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer. A packet probes from its home slot one entry per cycle: the
  // read for slot k+1 is issued while slot k is compared. The first empty slot
  // met on the way is kept for a possible insert. A sweep walks the slots in
  // index order until the last slot or the result budget, writing slot k back
  // while slot k+1 is read, so the two never touch the same entry.
  // --------------------------------------------------------------------------
  always_comb begin
    logic        is_strong;
    logic        hit;
    logic [31:0] dage;
    logic [31:0] sage;
    entry_t      e;
    logic        do_wr;
    logic        do_drop;
    logic        has_ev;
    event_t      ev;

    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    node_nxt       = node_r;
    rssi_nxt       = rssi_r;
    now_nxt        = now_r;
    slot_nxt       = slot_r;
    scan_cnt_nxt   = scan_cnt_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    evcnt_nxt      = evcnt_r;
    valid_nxt      = valid_r;
    occ_nxt        = occ_r;
    rd_en          = 1'b0;
    rd_addr        = slot_r;
    wr_en          = 1'b0;
    wr_addr        = slot_r;
    wr_data        = rdata_r;
    ev_ctl         = '0;

    is_strong = (rssi_r >= rssi_thr_r);
    hit       = valid_r[slot_r] && (rdata_r.node == node_r);
    dage      = now_r - rdata_r.detect;
    sage      = now_r - rdata_r.seen;
    e         = rdata_r;
    do_wr     = 1'b0;
    do_drop   = 1'b0;
    has_ev    = 1'b0;
    ev        = '{res: EV_NONE, node: node_r, etime: now_r};
    ev_data   = ev;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_tuser;
          node_nxt       = in_tdata[15:0];
          rssi_nxt       = $signed(in_tdata[23:16]);
          now_nxt        = in_tdata[55:24];
          rd_en          = 1'b1;
          rd_addr        = in_tuser ? '0 : in_tdata[SLOT_W-1:0];
          slot_nxt       = rd_addr;
          scan_cnt_nxt   = '0;
          free_found_nxt = 1'b0;
          evcnt_nxt      = '0;
          state_nxt      = in_tuser ? S_SW_EVAL : S_PK_SCAN;
        end
      end

      S_PK_SCAN: begin
        if (!valid_r[slot_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = slot_r;
        end
        if (hit) begin
          // hold slot and read data for the update
          hit_nxt   = 1'b1;
          state_nxt = S_PK_ACT;
        end else if (scan_cnt_r == LAST_SLOT) begin
          hit_nxt   = 1'b0;
          state_nxt = S_PK_ACT;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = slot_r + 1'b1;
          slot_nxt     = rd_addr;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      S_PK_ACT: begin
        if (hit_r) begin
          if (is_strong) begin
            case (rdata_r.phase)
              PH_NEAR: begin
                e.seen = now_r;
                do_wr  = 1'b1;
                if (dage >= prox_r) begin
                  e.phase = PH_PRESENT;
                  ev      = '{res: EV_DETECTED, node: node_r, etime: rdata_r.detect};
                end
              end
              PH_AWAY: begin
                e.phase = PH_PRESENT;
                e.seen  = now_r;
                do_wr   = 1'b1;
                ev.res  = EV_RETURNED;
              end
              PH_PRESENT: begin
                e.seen = now_r;
                do_wr  = 1'b1;
              end
              default: ;
            endcase
          end else begin
            case (rdata_r.phase)
              PH_PRESENT: begin
                e.detect = now_r;
                e.phase  = PH_AWAY;
                do_wr    = 1'b1;
                ev.res   = EV_LEAVING;
              end
              PH_NEAR: begin
                do_drop = 1'b1;
                ev.res  = EV_REMOVED;
              end
              PH_AWAY: begin
                if (dage >= away_r) begin
                  do_drop = 1'b1;
                  ev      = '{res: EV_ABSENT, node: node_r, etime: rdata_r.detect};
                end
              end
              default: ;
            endcase
          end
        end else if (is_strong) begin
          if ((occ_r < OCC_W'(TABLE_SIZE)) && free_found_r) begin
            ev.res = EV_INSERTED;
          end else begin
            ev.res = EV_FULL;
          end
        end
        ev_data = ev;
        if (ev_ready) begin
          ev_ctl.fin = 1'b1;
          state_nxt  = S_IDLE;
          if (do_wr) begin
            wr_en   = 1'b1;
            wr_data = e;
          end
          if (do_drop) begin
            valid_nxt[slot_r] = 1'b0;
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
          end
          if (ev.res == EV_INSERTED) begin
            // new sender starts approaching at the first free slot
            wr_en   = 1'b1;
            wr_addr = free_slot_r;
            wr_data = '{node: node_r, phase: PH_NEAR, detect: now_r, seen: now_r};
            valid_nxt[free_slot_r] = 1'b1;
            occ_nxt = occ_r + 1'b1;
          end
        end
      end

      S_SW_EVAL: begin
        ev.node = rdata_r.node;
        if (valid_r[slot_r]) begin
          case (rdata_r.phase)
            PH_NEAR: begin
              if (sage > stale_r) begin
                do_drop = 1'b1;
                has_ev  = 1'b1;
                ev.res  = EV_REMOVED;
              end
            end
            PH_PRESENT: begin
              if (sage > stale_r) begin
                e.detect = now_r;
                e.phase  = PH_AWAY;
                do_wr    = 1'b1;
                has_ev   = 1'b1;
                ev.res   = EV_LEAVING;
              end
            end
            PH_AWAY: begin
              if (dage >= away_r) begin
                do_drop  = 1'b1;
                has_ev   = 1'b1;
                ev.res   = EV_ABSENT;
                ev.etime = rdata_r.detect;
              end
            end
            default: ;
          endcase
        end
        ev_data = ev;
        // stall on a full result path only when this slot has something to say
        if (!has_ev || ev_ready) begin
          ev_ctl.push = has_ev;
          if (do_wr) begin
            wr_en   = 1'b1;
            wr_data = e;
          end
          if (do_drop) begin
            valid_nxt[slot_r] = 1'b0;
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
          end
          if (has_ev) begin
            evcnt_nxt = evcnt_r + 1'b1;
          end
          // stop at the end of the table or once the result budget is spent
          if ((slot_r == LAST_SLOT) ||
              (has_ev && (evcnt_r == EVC_W'(MAX_RESULTS - 1)))) begin
            state_nxt = S_SW_FIN;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = slot_r + 1'b1;
            slot_nxt = rd_addr;
          end
        end
      end

      S_SW_FIN: begin
        ev_data = '{res: EV_NONE, node: 16'd0, etime: now_r};
        if (ev_ready) begin
          ev_ctl.fin = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rssi_thr_r <= RSSI_THR_RST;
      prox_r     <= PROXIMITY_RST;
      away_r     <= AWAY_RST;
      stale_r    <= STALE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RSSI_THR:  rssi_thr_r <= $signed(cfg_pwdata[7:0]);
        REG_PROXIMITY: prox_r     <= cfg_pwdata;
        REG_AWAY:      away_r     <= cfg_pwdata;
        REG_STALE:     stale_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // item and walk payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    node_r       <= node_nxt;
    rssi_r       <= rssi_nxt;
    now_r        <= now_nxt;
    slot_r       <= slot_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    evcnt_r      <= evcnt_nxt;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  pnt_evout u_evout (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ev_ctl),
    .ev         (ev_data),
    .ev_ready   (ev_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_W'($countones(valid_r)))
    else $error("occupancy does not match the valid bits");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("new item taken while one is in progress");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_NONE)) |-> out_tlast)
    else $error("empty result that is not the last of its item");

  a_sweep_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (slot_r == '0))
    else $error("sweep did not start at slot zero");

endmodule
